/* hdl/fbd_pkg.sv */
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared types and constants for the page-organized monochrome framebuffer.
// ----------------------------------------------------------------------------
package fbd_pkg;

   localparam int DEF_COLUMNS = 128;
   localparam int DEF_PAGES   = 8;
   localparam logic [7:0] DIRTY_ALL = 8'hFF;

   typedef enum logic [2:0] {
      CMD_PIXEL  = 3'd0,
      CMD_FILL   = 3'd1,
      CMD_INVERT = 3'd2,
      CMD_CLEAR  = 3'd3,
      CMD_MARK   = 3'd4,
      CMD_READ   = 3'd5,
      CMD_TAKE   = 3'd6,
      CMD_NOP    = 3'd7
   } fbd_cmd_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_WRITE,
      S_FETCH,
      S_REPLY
   } fbd_state_type;

   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_MASK = 1'b1
   } fbd_kind_type;

   // one masked byte update for the modify unit
   typedef struct packed {
      logic       invert;
      logic       color;
      logic [7:0] mask;
   } fbd_rmw_op_type;

endpackage

/* hdl/monochrome_framebuffer_dirty_pages_top.sv */
// ----------------------------------------------------------------------------
// monochrome_framebuffer_dirty_pages_top
// Page-organized one-bit framebuffer with a dirty-page mask.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  req     | in        | req_valid req_ready cmd x_pos y_pos width height color page_sel
//  rsp     | out       | rsp_valid rsp_ready value kind
//
//  Rectangles and pixels run through one read-modify-write loop: each touched
//  byte is read, then written, after the accept cycle.
//  Clear all and reset sweep the memory, one byte a cycle.
//  Mark rows and take mask finish at acceptance; read byte runs fetch, then reply.
//  req_ready is low while a command runs or a result cannot be placed.
// ----------------------------------------------------------------------------
module monochrome_framebuffer_dirty_pages_top
   import fbd_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int PAGES   = DEF_PAGES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_x_pos,
   input  logic [7:0] req_y_pos,
   input  logic [7:0] req_width,
   input  logic [7:0] req_height,
   input  logic       req_color,
   input  logic [2:0] req_page_sel,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_value,
   output logic       rsp_kind
);
   localparam int DEPTH = COLUMNS * PAGES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [8:0] COLS9 = 9'(COLUMNS);
   localparam logic [8:0] ROWS9 = 9'(PAGES * 8);
   localparam logic [2:0] PLAST = 3'(PAGES - 1);

   fbd_state_type state_ff, state_in;

   logic [8:0]    col_ff, col_in, col_first_ff, col_first_in, col_last_ff, col_last_in;
   logic [2:0]    page_ff, page_in, page_last_ff, page_last_in;
   logic [8:0]    row_first_ff, row_first_in, row_last_ff, row_last_in;
   logic          invert_ff, invert_in, color_ff, color_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [7:0]    dirty_ff, dirty_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_value_ff, rsp_value_in;
   logic          rsp_kind_ff, rsp_kind_in;

   logic          accept;
   fbd_cmd_type   cmd;
   logic [8:0]    x9, y9, xe, ye, w9, h9, mark_sum;
   logic [2:0]    mk_first, mk_last;
   logic [5:0]    mk_first_raw, mk_last_raw;
   logic [7:0]    mk_mask;
   logic [AW:0]   addr_wide;
   logic [AW-1:0] addr, wr_addr;
   logic          wr_en;
   logic [7:0]    wr_data, rd_data, new_byte;
   logic          rmw_dirty;
   fbd_rmw_op_type op;

   fbd_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   fbd_rmw u_rmw (
      .op       (op),
      .old_byte (rd_data),
      .new_byte (new_byte),
      .dirty    (rmw_dirty)
   );

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign cmd       = fbd_cmd_type'(req_cmd);

   assign addr_wide = (AW+1)'(page_ff) * (AW+1)'(COLUMNS) + (AW+1)'(col_ff);
   assign addr      = addr_wide[AW-1:0];

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         op.mask[b] = ({3'(0), page_ff, 3'(b)} >= row_first_ff) &&
                      ({3'(0), page_ff, 3'(b)} <= row_last_ff);
      end
      op.invert = invert_ff;
      op.color  = color_ff;
   end

   // mark-rows page range
   always_comb begin
      mark_sum     = {1'b0, req_y_pos} + {1'b0, req_height};
      mk_first_raw = {1'b0, req_y_pos[7:3]};
      mk_last_raw  = (mark_sum == 9'd0) ? 6'd0 : 6'((mark_sum - 9'd1) >> 3);
      mk_first     = (mk_first_raw > {3'd0, PLAST}) ? PLAST : mk_first_raw[2:0];
      mk_last      = (mk_last_raw > {3'd0, PLAST}) ? PLAST : mk_last_raw[2:0];
      for (int p = 0; p < 8; p++) begin
         mk_mask[p] = (3'(p) >= mk_first) && (3'(p) <= mk_last);
      end
   end

   // rectangle clipping
   always_comb begin
      x9 = {1'b0, req_x_pos};
      y9 = {1'b0, req_y_pos};
      w9 = (cmd == CMD_PIXEL) ? 9'd1 : {1'b0, req_width};
      h9 = (cmd == CMD_PIXEL) ? 9'd1 : {1'b0, req_height};
      xe = x9 + w9;
      ye = y9 + h9;
      if (xe > COLS9) xe = COLS9;
      if (ye > ROWS9) ye = ROWS9;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         dirty_ff     <= DIRTY_ALL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff       <= col_in;
      col_first_ff <= col_first_in;
      col_last_ff  <= col_last_in;
      page_ff      <= page_in;
      page_last_ff <= page_last_in;
      row_first_ff <= row_first_in;
      row_last_ff  <= row_last_in;
      invert_ff    <= invert_in;
      color_ff     <= color_in;
      rsp_value_ff <= rsp_value_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      dirty_in     = dirty_ff;
      col_in       = col_ff;
      col_first_in = col_first_ff;
      col_last_in  = col_last_ff;
      page_in      = page_ff;
      page_last_in = page_last_ff;
      row_first_in = row_first_ff;
      row_last_in  = row_last_ff;
      invert_in    = invert_ff;
      color_in     = color_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_kind_in  = rsp_kind_ff;
      wr_en        = 1'b0;
      wr_addr      = addr;
      wr_data      = new_byte;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = 8'd0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               clr_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               unique case (cmd) inside
                  CMD_PIXEL, CMD_FILL, CMD_INVERT: begin
                     invert_in    = (cmd == CMD_INVERT);
                     color_in     = req_color;
                     col_in       = x9;
                     col_first_in = x9;
                     col_last_in  = xe - 9'd1;
                     page_in      = req_y_pos[5:3];
                     page_last_in = 3'((ye - 9'd1) >> 3);
                     row_first_in = y9;
                     row_last_in  = ye - 9'd1;
                     if (x9 < COLS9 && y9 < ROWS9 && w9 != 9'd0 && h9 != 9'd0) begin
                        state_in = S_READ;
                     end
                  end
                  CMD_CLEAR: begin
                     dirty_in = DIRTY_ALL;
                     state_in = S_CLEAR;
                  end
                  CMD_MARK: dirty_in = dirty_ff | mk_mask;
                  CMD_READ: begin
                     col_in  = x9;
                     page_in = req_page_sel;
                     if (x9 < COLS9 && {1'b0, req_page_sel} <= {1'b0, PLAST}) begin
                        state_in = S_FETCH;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_value_in = 8'd0;
                        rsp_kind_in  = KIND_BYTE;
                     end
                  end
                  CMD_TAKE: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = dirty_ff;
                     rsp_kind_in  = KIND_MASK;
                     dirty_in     = 8'd0;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: state_in = S_WRITE;
         S_WRITE: begin
            wr_en = 1'b1;
            if (rmw_dirty) begin
               dirty_in = dirty_ff | (8'd1 << page_ff);
            end
            state_in = S_READ;
            if (col_ff == col_last_ff) begin
               col_in  = col_first_ff;
               page_in = page_ff + 3'd1;
               if (page_ff == page_last_ff) begin
                  state_in = S_IDLE;
               end
            end else begin
               col_in = col_ff + 9'd1;
            end
         end
         S_FETCH: state_in = S_REPLY;
         S_REPLY: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = rd_data;
            rsp_kind_in  = KIND_BYTE;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_kind  = rsp_kind_ff;
endmodule

/* hdl/fbd_store.sv */
// ----------------------------------------------------------------------------
// fbd_store
// Pixel byte memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fbd_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/fbd_rmw.sv */
// ----------------------------------------------------------------------------
// fbd_rmw
// Shared byte modify unit: set, clear or invert the masked bits of a byte.
// ----------------------------------------------------------------------------
module fbd_rmw (
   input  fbd_pkg::fbd_rmw_op_type op,
   input  logic [7:0]              old_byte,
   output logic [7:0]              new_byte,
   output logic                    dirty
);
   import fbd_pkg::*;

   always_comb begin
      if (op.invert) begin
         new_byte = old_byte ^ op.mask;
         dirty    = 1'b1;
      end else begin
         new_byte = op.color ? (old_byte | op.mask) : (old_byte & ~op.mask);
         dirty    = (new_byte != old_byte);
      end
   end
endmodule

/* tb/monochrome_framebuffer_dirty_pages_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// monochrome_framebuffer_dirty_pages_top_test
// Drives drawing, clearing, marking and read commands into the framebuffer,
// keeps a shadow copy of the pixel bytes and the dirty mask, and checks every
// returned word against it in order, under three idling patterns.
// ----------------------------------------------------------------------------
module monochrome_framebuffer_dirty_pages_top_test;
   import fbd_pkg::*;

   localparam int COLS  = DEF_COLUMNS;
   localparam int PGS   = DEF_PAGES;
   localparam int ROWS  = PGS * 8;
   localparam int N_RANDOM = 560;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_cmd = CMD_NOP;
   logic [7:0] req_x_pos = '0, req_y_pos = '0, req_width = '0, req_height = '0;
   logic       req_color = 1'b0;
   logic [2:0] req_page_sel = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_value;
   logic       rsp_kind;

   monochrome_framebuffer_dirty_pages_top uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      fbd_cmd_type cmd;
      logic [7:0]  x, y, w, h;
      logic        color;
      logic [2:0]  page;
   } draw_word_type;

   typedef struct packed {
      logic [7:0]   value;
      fbd_kind_type kind;
   } reply_word_type;

   // directed row: a word plus an optional typed-in reply
   typedef struct packed {
      draw_word_type  word;
      logic           fixed;
      reply_word_type reply;
   } directed_row_type;

   logic [7:0]     shadow_bytes [PGS*COLS];
   logic [7:0]     shadow_dirty;
   reply_word_type pending_replies [$];
   int             mismatches = 0;
   int             replies_seen = 0;
   int             send_idle_pct = 0, recv_idle_pct = 0;
   bit             sending_done = 0;

   function automatic void shadow_pixel(int col, int row, logic color);
      int idx;
      logic [7:0] bitm;
      if (col >= COLS || row >= ROWS) return;
      idx  = (row >> 3) * COLS + col;
      bitm = 8'd1 << (row & 7);
      if (((shadow_bytes[idx] & bitm) != 0) != color) begin
         shadow_bytes[idx] ^= bitm;
         shadow_dirty[row >> 3] = 1'b1;
      end
   endfunction

   // updates the shadow; returns 1 and fills rep when a reply is due
   function automatic bit shadow_apply(draw_word_type d, output reply_word_type rep);
      int x, y, w, h, last, first, lastp, idx;
      x = d.x; y = d.y; w = d.w; h = d.h;
      rep = '0;
      case (d.cmd)
         CMD_PIXEL: shadow_pixel(x, y, d.color);
         CMD_FILL, CMD_INVERT: begin
            if (x < COLS && y < ROWS) begin
               if (x + w > COLS) w = COLS - x;
               if (y + h > ROWS) h = ROWS - y;
               for (int r = y; r < y + h; r++)
                  for (int c = x; c < x + w; c++)
                     if (d.cmd == CMD_FILL) shadow_pixel(c, r, d.color);
                     else begin
                        idx = (r >> 3) * COLS + c;
                        shadow_bytes[idx] ^= 8'd1 << (r & 7);
                        shadow_dirty[r >> 3] = 1'b1;
                     end
            end
         end
         CMD_CLEAR: begin
            foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
            shadow_dirty = DIRTY_ALL;
         end
         CMD_MARK: begin
            last  = y + h - 1;
            first = y >> 3;
            lastp = (last < 0) ? 0 : (last >> 3);
            if (first > PGS - 1) first = PGS - 1;
            if (lastp > PGS - 1) lastp = PGS - 1;
            for (int p = first; p <= lastp; p++) shadow_dirty[p] = 1'b1;
         end
         CMD_READ: begin
            rep.kind  = KIND_BYTE;
            rep.value = (x < COLS && d.page < PGS) ? shadow_bytes[d.page*COLS + x] : 8'd0;
            return 1;
         end
         CMD_TAKE: begin
            rep.kind  = KIND_MASK;
            rep.value = shadow_dirty;
            shadow_dirty = '0;
            return 1;
         end
         default: ;
      endcase
      return 0;
   endfunction

   // called at a falling edge; valid stays up between words unless idling
   task automatic send_word(draw_word_type d);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= d.cmd;
      req_x_pos    <= d.x;
      req_y_pos    <= d.y;
      req_width    <= d.w;
      req_height   <= d.h;
      req_color    <= d.color;
      req_page_sel <= d.page;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // random word biased toward small rectangles and on-screen positions
   function automatic draw_word_type random_word();
      draw_word_type d;
      d.cmd   = fbd_cmd_type'($urandom_range(7));
      d.x     = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(COLS-1));
      d.y     = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(ROWS-1));
      d.w     = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(12));
      d.h     = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(12));
      d.color = 1'($urandom);
      d.page  = 3'($urandom);
      if (d.cmd == CMD_CLEAR && $urandom_range(3) != 0) d.cmd = CMD_READ;
      return d;
   endfunction

   task automatic drain_replies();
      while (pending_replies.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // checker
   always @(posedge clock) begin
      reply_word_type exp_rep;
      if (!reset && rsp_valid && rsp_ready) begin
         replies_seen++;
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: value %h kind %b", rsp_value, rsp_kind);
         end else begin
            exp_rep = pending_replies.pop_front();
            if (exp_rep.value !== rsp_value || exp_rep.kind !== rsp_kind) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected value %h kind %b, got value %h kind %b",
                           exp_rep.value, exp_rep.kind, rsp_value, rsp_kind);
            end
         end
      end
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);

   directed_row_type directed [] = '{
      //  cmd        x      y      w      h     col  page  fixed  reply
      '{'{CMD_TAKE,  8'd0,  8'd0,  8'd0,  8'd0, 1'b0, 3'd0}, 1'b1, '{8'hFF, KIND_MASK}},
      '{'{CMD_READ,  8'd0,  8'd0,  8'd0,  8'd0, 1'b0, 3'd0}, 1'b1, '{8'h00, KIND_BYTE}},
      '{'{CMD_TAKE,  8'd0,  8'd0,  8'd0,  8'd0, 1'b0, 3'd0}, 1'b1, '{8'h00, KIND_MASK}},
      '{'{CMD_PIXEL, 8'd127,8'd63, 8'd0,  8'd0, 1'b1, 3'd0}, 1'b0, '0},
      '{'{CMD_PIXEL, 8'd127,8'd63, 8'd0,  8'd0, 1'b1, 3'd0}, 1'b0, '0},
      '{'{CMD_READ,  8'd127,8'd0,  8'd0,  8'd0, 1'b0, 3'd7}, 1'b1, '{8'h80, KIND_BYTE}},
      '{'{CMD_TAKE,  8'd0,  8'd0,  8'd0,  8'd0, 1'b0, 3'd0}, 1'b1, '{8'h80, KIND_MASK}},
      '{'{CMD_PIXEL, 8'd128,8'd0,  8'd0,  8'd0, 1'b1, 3'd0}, 1'b0, '0},
      '{'{CMD_PIXEL, 8'd0,  8'd255,8'd0,  8'd0, 1'b1, 3'd0}, 1'b0, '0},
      '{'{CMD_TAKE,  8'd0,  8'd0,  8'd0,  8'd0, 1'b0, 3'd0}, 1'b1, '{8'h00, KIND_MASK}},
      '{'{CMD_FILL,  8'd120,8'd60, 8'd255,8'd255,1'b1,3'd0}, 1'b0, '0},
      '{'{CMD_FILL,  8'd200,8'd0,  8'd5,  8'd5, 1'b1, 3'd0}, 1'b0, '0},
      '{'{CMD_INVERT,8'd0,  8'd0,  8'd3,  8'd9, 1'b0, 3'd0}, 1'b0, '0},
      '{'{CMD_INVERT,8'd5,  8'd70, 8'd3,  8'd3, 1'b0, 3'd0}, 1'b0, '0},
      '{'{CMD_INVERT,8'd5,  8'd16, 8'd0,  8'd4, 1'b0, 3'd0}, 1'b0, '0},
      '{'{CMD_TAKE,  8'd0,  8'd0,  8'd0,  8'd0, 1'b0, 3'd0}, 1'b0, '0},
      '{'{CMD_MARK,  8'd0,  8'd0,  8'd0,  8'd0, 1'b0, 3'd0}, 1'b0, '0},
      '{'{CMD_MARK,  8'd0,  8'd16, 8'd0,  8'd0, 1'b0, 3'd0}, 1'b0, '0},
      '{'{CMD_MARK,  8'd0,  8'd250,8'd0,  8'd255,1'b0,3'd0}, 1'b0, '0},
      '{'{CMD_TAKE,  8'd0,  8'd0,  8'd0,  8'd0, 1'b0, 3'd0}, 1'b0, '0},
      '{'{CMD_READ,  8'd255,8'd0,  8'd0,  8'd0, 1'b0, 3'd3}, 1'b1, '{8'h00, KIND_BYTE}},
      '{'{CMD_NOP,   8'd255,8'd255,8'd255,8'd255,1'b1,3'd7}, 1'b0, '0},
      '{'{CMD_CLEAR, 8'd0,  8'd0,  8'd0,  8'd0, 1'b0, 3'd0}, 1'b0, '0},
      '{'{CMD_TAKE,  8'd0,  8'd0,  8'd0,  8'd0, 1'b0, 3'd0}, 1'b1, '{8'hFF, KIND_MASK}},
      '{'{CMD_FILL,  8'd0,  8'd0,  8'd255,8'd255,1'b1,3'd0}, 1'b0, '0}
   };

   initial begin
      reply_word_type rep;
      bit has_rep;
      foreach (shadow_bytes[i]) shadow_bytes[i] = '0;
      shadow_dirty = DIRTY_ALL;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 73 : 0;
         recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 23 : 0;
         if (phase == 0)
            foreach (directed[i]) begin
               has_rep = shadow_apply(directed[i].word, rep);
               if (directed[i].fixed && rep !== directed[i].reply) begin
                  mismatches++;
                  $display("row %0d: predicted %h differs from table %h", i, rep,
                           directed[i].reply);
               end
               if (has_rep) pending_replies.push_back(rep);
               send_word(directed[i].word);
            end
         for (int n = 0; n < N_RANDOM / 3; n++) begin
            draw_word_type d;
            d = random_word();
            if (shadow_apply(d, rep)) pending_replies.push_back(rep);
            send_word(d);
         end
      end
      req_valid <= 1'b0;
      drain_replies();
      $display("covered %0d directed and %0d random words, %0d replies checked",
               directed.size(), 3 * (N_RANDOM / 3), replies_seen);
      if (mismatches == 0 && pending_replies.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #100ms;
      $display("== FAIL ==");
      $finish;
   end
endmodule

/* files.f */
hdl/fbd_pkg.sv
hdl/fbd_store.sv
hdl/fbd_rmw.sv
hdl/monochrome_framebuffer_dirty_pages_top.sv
tb/monochrome_framebuffer_dirty_pages_top_test.sv
